>>> rtl/core/irs_pkg.sv
package irs_pkg;

   // input kinds and scaling modes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic MODE_NEAREST = 1'b0;
   localparam logic MODE_LINEAR  = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] REG_SCALE_MODE    = 2'd0;
   localparam logic [1:0] REG_SCALE_FACTOR  = 2'd1;
   localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd2;
   localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd3;

   // fixed point
   localparam int FRAC_W  = 12;
   localparam int WGT_W   = 13;
   localparam int ONE     = 4096;
   localparam int HALF    = 2048;
   localparam int COORD_W = 26;
   localparam int IDX_W   = 12;

   // shared divider widths
   localparam int NUM_W = 37;
   localparam int DEN_W = 25;

   localparam int NUM_CHAN = 3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_CHECK,
      S_SETUP,
      S_TAP_RD,
      S_TAP_ACC,
      S_FIN_GO,
      S_FIN_WAIT,
      S_DONE
   } state_type;

   // tap range and edge weights of one axis
   typedef struct packed {
      logic [COORD_W-1:0] f;
      logic [COORD_W-1:0] l;
      logic [WGT_W-1:0]   w_first;
      logic [WGT_W-1:0]   w_last;
      logic [IDX_W-1:0]   lo;
      logic [IDX_W-1:0]   hi;
   } axis_type;

endpackage

>>> rtl/core/image_resampling_scaler_top.sv
// channel | direction | contents
// req     | in        | tuser: opcode; tdata: pos_x, pos_y, in_red, in_green, in_blue
// rsp     | out       | tuser: out_of_range; tdata: out_red, out_green, out_blue
// csr     | in        | index 0 scale_mode, 1 scale_factor, 2 source_width, 3 source_height
//
// a write beat is taken while idle; a sample beat holds req_tready low until done
// nearest: 2 quotients from the serial divider (one step per quotient bit), 1 tap
// bilinear: 2 quotients, up to 4 taps, 3 divides; area: 4 quotients, taps, 3 multiplies
// the source store has undefined contents after reset and no clearing pass
// a finished result waits in the rsp register; the sequencer stalls before
// loading it while the previous result is still held
module image_resampling_scaler_top
   import irs_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_x, pos_y, in_red, in_green, in_blue
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_red, out_green, out_blue
   output logic        rsp_tuser,   // out_of_range
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int ACC_W = 33 + XW + YW;
   localparam int PW    = ACC_W + 32;
   localparam int SUM_W = 26;
   localparam int WT_W  = 2 * WGT_W;

   // configuration registers
   logic        scale_mode_ff;
   logic [15:0] scale_factor_ff;
   logic [8:0]  src_w_ff;
   logic [8:0]  src_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mode_ff   <= MODE_NEAREST;
         scale_factor_ff <= 16'd4096;
         src_w_ff        <= 9'd256;
         src_h_ff        <= 9'd256;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SCALE_MODE:    scale_mode_ff   <= csr_wdata[0];
            REG_SCALE_FACTOR:  scale_factor_ff <= csr_wdata;
            REG_SOURCE_WIDTH:  src_w_ff        <= csr_wdata[8:0];
            REG_SOURCE_HEIGHT: src_h_ff        <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   logic [12:0] eff_w, eff_h;
   logic [15:0] scale_eff;

   assign eff_w = (13'(src_w_ff) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(src_w_ff);
   assign eff_h = (13'(src_h_ff) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(src_h_ff);
   assign scale_eff = (scale_factor_ff == 16'd0) ? 16'd1 : scale_factor_ff;

   // request fields
   logic [11:0] in_px, in_py;
   logic [23:0] in_rgb;
   logic        req_acc;

   assign in_px   = req_tdata[11:0];
   assign in_py   = req_tdata[23:12];
   assign in_rgb  = req_tdata[47:24];
   assign req_acc = req_tvalid & req_tready;

   // axis setup: tap range and edge weights from start and end coordinates
   function automatic axis_type axis_setup(input logic [NUM_W-1:0] q_lo,
                                           input logic [NUM_W-1:0] q_hi,
                                           input logic [12:0] lim,
                                           input logic bilin,
                                           input logic area);
      logic signed [NUM_W:0] a;
      logic signed [NUM_W:0] b;
      logic [COORD_W-1:0]    lim_m1;
      axis_type              r;
      a = signed'({1'b0, q_lo});
      if (bilin) a = a - (NUM_W+1)'(HALF);
      b = a;
      if (bilin) b = a + (NUM_W+1)'(ONE);
      else if (area) b = signed'({1'b0, q_hi});
      r.f       = a[NUM_W:FRAC_W];
      r.l       = b[NUM_W:FRAC_W];
      r.w_first = WGT_W'(ONE) - {1'b0, a[FRAC_W-1:0]};
      r.w_last  = {1'b0, b[FRAC_W-1:0]};
      r.lo      = r.f[COORD_W-1] ? '0 : r.f[IDX_W-1:0];
      lim_m1    = COORD_W'(lim) - COORD_W'(1);
      if (!bilin && !area) r.hi = r.f[IDX_W-1:0];
      else if (r.l > lim_m1) r.hi = lim_m1[IDX_W-1:0];
      else r.hi = r.l[IDX_W-1:0];
      return r;
   endfunction

   function automatic logic [WGT_W-1:0] tap_weight(input logic [IDX_W-1:0] i,
                                                   input axis_type ax);
      logic [COORD_W-1:0] iw;
      iw = COORD_W'(i);
      if (iw == ax.f) return ax.w_first;
      else if (iw == ax.l) return ax.w_last;
      else return WGT_W'(ONE);
   endfunction

   // sequencer state
   state_type state_ff, state_in;

   logic [11:0]      px_ff, py_ff;
   logic             bilin_ff, area_ff;
   logic [1:0]       div_idx_ff;
   logic [NUM_W-1:0] q_ff [4];
   axis_type         ax_ff, ay_ff;
   logic [XW-1:0]    x_ff;
   logic [YW-1:0]    y_ff;
   logic [23:0]      rd_data_ff;
   logic [WT_W-1:0]  wt_ff;
   logic [ACC_W-1:0] acc_ff [NUM_CHAN];
   logic [SUM_W-1:0] sum_ff;
   logic [31:0]      ss_ff;
   logic [PW-1:0]    prod_ff;
   logic [4:0]       k_ff;
   logic [1:0]       ch_ff;
   logic [7:0]       col_ff [NUM_CHAN];
   logic             oor_ff;
   logic             rsp_valid_ff;
   logic [23:0]      rsp_data_ff;
   logic             rsp_oor_ff;

   // shared divider
   logic             div_start, div_busy, div_done;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [DEN_W-1:0] div_den;
   logic [11:0]      div_pos;

   assign div_pos = div_idx_ff[0] ? py_ff : px_ff;

   always_comb begin
      if (state_ff == S_FIN_GO) begin
         div_num = NUM_W'(acc_ff[ch_ff]);
         div_den = DEN_W'(sum_ff);
      end else begin
         div_den = DEN_W'(scale_eff);
         if (div_idx_ff[1]) div_num = NUM_W'({13'(div_pos) + 13'd1, 24'd0});
         else if (bilin_ff) div_num = NUM_W'({div_pos, 1'b1, 23'd0});
         else div_num = NUM_W'({div_pos, 24'd0});
      end
   end

   irs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // decisions used by the sequencer
   logic     oor_hit, tap_last, fin_step_done, sum_zero, rsp_free;
   axis_type ax_new, ay_new;

   assign oor_hit  = (q_ff[0][NUM_W-1:FRAC_W] >= 25'(eff_w)) ||
                     (q_ff[1][NUM_W-1:FRAC_W] >= 25'(eff_h));
   assign tap_last = (x_ff == ax_ff.hi[XW-1:0]) && (y_ff == ay_ff.hi[YW-1:0]);
   assign fin_step_done = bilin_ff ? div_done : (k_ff == 5'd31);
   assign sum_zero = (sum_ff == '0);
   assign rsp_free = ~rsp_valid_ff | rsp_tready;
   assign ax_new   = axis_setup(q_ff[0], q_ff[2], eff_w, bilin_ff, area_ff);
   assign ay_new   = axis_setup(q_ff[1], q_ff[3], eff_h, bilin_ff, area_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_acc && req_tuser == OP_SAMPLE) state_in = S_DIV_GO;
         S_DIV_GO:   state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_done) begin
               if (div_idx_ff == 2'd1) state_in = S_CHECK;
               else if (div_idx_ff == 2'd3) state_in = S_SETUP;
               else state_in = S_DIV_GO;
            end
         end
         S_CHECK: begin
            if (oor_hit) state_in = S_DONE;
            else if (area_ff) state_in = S_DIV_GO;
            else state_in = S_SETUP;
         end
         S_SETUP:    state_in = S_TAP_RD;
         S_TAP_RD:   state_in = S_TAP_ACC;
         S_TAP_ACC: begin
            if (!tap_last) state_in = S_TAP_RD;
            else if (!bilin_ff && !area_ff) state_in = S_DONE;
            else state_in = S_FIN_GO;
         end
         S_FIN_GO: begin
            if (bilin_ff && sum_zero) state_in = S_DONE;
            else state_in = S_FIN_WAIT;
         end
         S_FIN_WAIT: begin
            if (fin_step_done) state_in = (ch_ff == 2'd2) ? S_DONE : S_FIN_GO;
         end
         S_DONE:     if (rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   logic done_load;

   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      done_load  = 1'b0;
      case (state_ff)
         S_IDLE:   req_tready = 1'b1;
         S_DIV_GO: div_start = 1'b1;
         S_FIN_GO: div_start = bilin_ff & ~sum_zero;
         S_DONE:   done_load = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // source store
   logic [23:0]   mem [DEPTH];
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;

   assign wr_en   = req_acc && (req_tuser == OP_WRITE) &&
                    (13'(in_px) < 13'(MAX_WIDTH)) && (13'(in_py) < 13'(MAX_HEIGHT));
   assign wr_addr = AW'(32'(in_py) * MAX_WIDTH + 32'(in_px));
   assign rd_addr = AW'(32'(y_ff) * MAX_WIDTH + 32'(x_ff));

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= in_rgb;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_TAP_RD) rd_data_ff <= mem[rd_addr];
   end

   // area scaling: acc times scale squared, one bit per cycle
   logic [PW-1:0] prod_nx;

   assign prod_nx = {prod_ff[PW-2:0], 1'b0} +
                    (ss_ff[5'd31 - k_ff] ? PW'(acc_ff[ch_ff]) : PW'(0));

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_tuser == OP_SAMPLE) begin
               px_ff      <= in_px;
               py_ff      <= in_py;
               bilin_ff   <= (scale_mode_ff == MODE_LINEAR) && (scale_eff > 16'd4096);
               area_ff    <= (scale_mode_ff == MODE_LINEAR) && (scale_eff <= 16'd4096);
               div_idx_ff <= 2'd0;
               oor_ff     <= 1'b0;
               for (int c = 0; c < NUM_CHAN; c++) col_ff[c] <= 8'd0;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               q_ff[div_idx_ff] <= div_quot;
               div_idx_ff       <= div_idx_ff + 2'd1;
            end
         end
         S_CHECK: if (oor_hit) oor_ff <= 1'b1;
         S_SETUP: begin
            ax_ff  <= ax_new;
            ay_ff  <= ay_new;
            x_ff   <= ax_new.lo[XW-1:0];
            y_ff   <= ay_new.lo[YW-1:0];
            sum_ff <= '0;
            ch_ff  <= 2'd0;
            ss_ff  <= scale_eff * scale_eff;
            for (int c = 0; c < NUM_CHAN; c++) acc_ff[c] <= '0;
         end
         S_TAP_RD: begin
            wt_ff <= tap_weight(IDX_W'(y_ff), ay_ff) * tap_weight(IDX_W'(x_ff), ax_ff);
         end
         S_TAP_ACC: begin
            // taps with zero weight add nothing and are skipped
            if (wt_ff != '0) begin
               for (int c = 0; c < NUM_CHAN; c++)
                  acc_ff[c] <= acc_ff[c] +
                               ACC_W'(34'(wt_ff) * 34'(rd_data_ff[8*c +: 8]));
               sum_ff <= sum_ff + SUM_W'(wt_ff);
            end
            for (int c = 0; c < NUM_CHAN; c++)
               if (!bilin_ff && !area_ff) col_ff[c] <= rd_data_ff[8*c +: 8];
            // raster walk over the footprint
            if (x_ff == ax_ff.hi[XW-1:0]) begin
               x_ff <= ax_ff.lo[XW-1:0];
               if (y_ff != ay_ff.hi[YW-1:0]) y_ff <= y_ff + 1'b1;
            end else begin
               x_ff <= x_ff + 1'b1;
            end
         end
         S_FIN_GO: begin
            prod_ff <= '0;
            k_ff    <= 5'd0;
            if (bilin_ff && sum_zero) oor_ff <= 1'b1;
         end
         S_FIN_WAIT: begin
            if (!bilin_ff) begin
               prod_ff <= prod_nx;
               k_ff    <= k_ff + 5'd1;
            end
            if (fin_step_done) begin
               if (bilin_ff)
                  col_ff[ch_ff] <= (|div_quot[NUM_W-1:8]) ? 8'hFF : div_quot[7:0];
               else
                  col_ff[ch_ff] <= (|prod_nx[PW-1:56]) ? 8'hFF : prod_nx[55:48];
               ch_ff <= ch_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_load) begin
         rsp_data_ff <= oor_ff ? 24'd0 : {col_ff[2], col_ff[1], col_ff[0]};
         rsp_oor_ff  <= oor_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_oor_ff;

`ifndef SYNTH
   // divider only runs while a sample is being worked on
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_busy)
      else $error("divider busy while idle");

   // an out of range result carries no colour
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 24'd0))
      else $error("out of range result with colour");

   // a write beat never produces a result
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == OP_WRITE && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result after write beat");

   // the footprint walk stays inside the clamped tap range
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAP_RD) |->
         (x_ff <= ax_ff.hi[XW-1:0]) && (y_ff <= ay_ff.hi[YW-1:0]))
      else $error("tap outside footprint");
`endif

endmodule

>>> rtl/core/irs_div.sv
module irs_div
   import irs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W:0]   rem_ff;
   logic [NUM_W-1:0] quot_ff;
   logic [DEN_W-1:0] den_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] diff;
   logic             ge;

   // one quotient bit per cycle, restoring
   assign rem_sh = {rem_ff[DEN_W-1:0], quot_ff[NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign ge     = ~diff[DEN_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= num;
         rem_ff  <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[DEN_W:0] : rem_sh;
         quot_ff <= {quot_ff[NUM_W-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> bench/tb_image_resampling_scaler_top.sv
`timescale 1ns / 1ps

module tb_image_resampling_scaler_top;
   import irs_pkg::*;

   localparam int STORE_W = 256;
   localparam int STORE_H = 256;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       oor;
   } pixel_result_type;

   // in-order store of predicted output pixels
   class pixel_scoreboard;
      pixel_result_type pending[$];
      int               errors = 0;

      function void note_sample(pixel_result_type exp_pix);
         pending.push_back(exp_pix);
      endfunction

      function void check_pixel(pixel_result_type got);
         pixel_result_type exp_pix;
         if (pending.size() == 0) begin
            $error("unexpected pixel: red %0d green %0d blue %0d oor %0d",
                   got.red, got.green, got.blue, got.oor);
            errors++;
            return;
         end
         exp_pix = pending.pop_front();
         if (got.red !== exp_pix.red) begin
            $error("out_red: expected %0d actual %0d", exp_pix.red, got.red);
            errors++;
         end
         if (got.green !== exp_pix.green) begin
            $error("out_green: expected %0d actual %0d", exp_pix.green, got.green);
            errors++;
         end
         if (got.blue !== exp_pix.blue) begin
            $error("out_blue: expected %0d actual %0d", exp_pix.blue, got.blue);
            errors++;
         end
         if (got.oor !== exp_pix.oor) begin
            $error("out_of_range: expected %0d actual %0d", exp_pix.oor, got.oor);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   image_resampling_scaler_top dut (.*);

   pixel_scoreboard sb = new();

   // shadow of the source image and of the registers
   logic [23:0] src_image [0:STORE_W*STORE_H-1];
   bit          src_valid [0:STORE_W*STORE_H-1];
   logic        mode_q;
   logic [15:0] scale_q;
   logic [8:0]  width_q;
   logic [8:0]  height_q;
   int          send_idle;
   int          recv_stall;
   bit          read_unwritten;

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // fetch one source channel, flag reads of unwritten pixels
   function automatic longint unsigned fetch_chan(longint unsigned x, longint unsigned y,
                                                  int c);
      int idx;
      idx = int'(y) * STORE_W + int'(x);
      if (!src_valid[idx]) read_unwritten = 1;
      return longint'((src_image[idx] >> (8 * c)) & 24'hFF);
   endfunction

   function automatic longint unsigned box_weight(longint unsigned i, longint unsigned a,
                                                  longint unsigned b);
      longint unsigned af, bf;
      af = a >> 12;
      bf = b >> 12;
      if (i == af) return ((af + 1) << 12) - a;
      if (i == bf) return b - (bf << 12);
      return 4096;
   endfunction

   // predicted output pixel for a sample at (px, py)
   function automatic pixel_result_type resample_pixel(longint unsigned px,
                                                       longint unsigned py);
      pixel_result_type res;
      longint unsigned  w, h, s, ex, ey, ax, ay, bx, by, xe, ye, wt, sum, cy, cx;
      longint unsigned  fx[2], fy[2], acc[3], col[3];
      longint           nx, ny, xx, yy;
      res = '{8'd0, 8'd0, 8'd0, 1'b1};
      w = (width_q > STORE_W) ? STORE_W : width_q;
      h = (height_q > STORE_H) ? STORE_H : height_q;
      s = (scale_q == 0) ? 1 : scale_q;
      acc = '{0, 0, 0};
      col = '{0, 0, 0};
      if (mode_q == MODE_LINEAR && s > 4096) begin
         // bilinear, center aligned
         ex = ((2 * px + 1) << 24) / (2 * s);
         ey = ((2 * py + 1) << 24) / (2 * s);
         if ((ex >> 12) >= w || (ey >> 12) >= h) return res;
         nx = (ex < 2048) ? -1 : longint'((ex - 2048) >> 12);
         ny = (ey < 2048) ? -1 : longint'((ey - 2048) >> 12);
         fx[1] = longint'(ex) - (nx * 4096 + 2048);
         fx[0] = 4096 - fx[1];
         fy[1] = longint'(ey) - (ny * 4096 + 2048);
         fy[0] = 4096 - fy[1];
         sum = 0;
         for (int ky = 0; ky < 2; ky++) begin
            yy = ny + ky;
            if (yy < 0 || yy >= longint'(h)) continue;
            for (int kx = 0; kx < 2; kx++) begin
               xx = nx + kx;
               if (xx < 0 || xx >= longint'(w)) continue;
               wt = fy[ky] * fx[kx];
               for (int c = 0; c < 3; c++) acc[c] += wt * fetch_chan(xx, yy, c);
               sum += wt;
            end
         end
         if (sum == 0) return res;
         for (int c = 0; c < 3; c++) col[c] = acc[c] / sum;
      end else begin
         ax = (px << 24) / s;
         ay = (py << 24) / s;
         if ((ax >> 12) >= w || (ay >> 12) >= h) return res;
         if (mode_q == MODE_NEAREST) begin
            for (int c = 0; c < 3; c++) col[c] = fetch_chan(ax >> 12, ay >> 12, c);
         end else begin
            // box average over the footprint
            bx = ((px + 1) << 24) / s;
            by = ((py + 1) << 24) / s;
            xe = bx >> 12;
            ye = by >> 12;
            if (xe > w - 1) xe = w - 1;
            if (ye > h - 1) ye = h - 1;
            for (longint unsigned y = ay >> 12; y <= ye; y++) begin
               cy = box_weight(y, ay, by);
               for (longint unsigned x = ax >> 12; x <= xe; x++) begin
                  cx = box_weight(x, ax, bx);
                  if (cy == 0 || cx == 0) continue;
                  for (int c = 0; c < 3; c++) acc[c] += cy * cx * fetch_chan(x, y, c);
               end
            end
            for (int c = 0; c < 3; c++) col[c] = ((acc[c] * s) * s) >> 48;
         end
      end
      res.red   = (col[0] > 255) ? 8'd255 : col[0][7:0];
      res.green = (col[1] > 255) ? 8'd255 : col[1][7:0];
      res.blue  = (col[2] > 255) ? 8'd255 : col[2][7:0];
      res.oor   = 1'b0;
      return res;
   endfunction

   // one beat on the req channel, called at a rising edge
   task automatic send_beat(logic op, logic [11:0] px, logic [11:0] py, logic [23:0] rgb);
      int idx;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {rgb[23:16], rgb[15:8], rgb[7:0], py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_WRITE) begin
         if (px < STORE_W && py < STORE_H) begin
            idx = int'(py) * STORE_W + int'(px);
            src_image[idx] = rgb;
            src_valid[idx] = 1;
         end
      end else begin
         sb.note_sample(resample_pixel(px, py));
      end
   endtask

   // sample only where every tap has been loaded
   task automatic send_sample(logic [11:0] px, logic [11:0] py);
      read_unwritten = 0;
      void'(resample_pixel(px, py));
      if (!read_unwritten) send_beat(OP_SAMPLE, px, py, 24'd0);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] addr, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (addr)
         REG_SCALE_MODE:    mode_q   = value[0];
         REG_SCALE_FACTOR:  scale_q  = value;
         REG_SOURCE_WIDTH:  width_q  = value[8:0];
         REG_SOURCE_HEIGHT: height_q = value[8:0];
         default: ;
      endcase
   endtask

   // output coordinate that mostly lands near the loaded corner of the source
   function automatic logic [11:0] near_coord();
      longint unsigned s, p;
      s = (scale_q == 0) ? 1 : scale_q;
      if ($urandom_range(5) == 0) return 12'($urandom);
      p = ((longint'($urandom_range(13)) * s) >> 12) + $urandom_range(2);
      return (p > 4095) ? 12'hFFF : p[11:0];
   endfunction

   // receive side
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_pixel('{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser});
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   initial begin
      #10_000_000;
      $display("[image_resampling_scaler_top] ERROR");
      $finish;
   end

   initial begin
      logic        ph_mode   [1:10] = '{MODE_LINEAR, MODE_LINEAR, MODE_LINEAR, MODE_LINEAR,
                                       MODE_LINEAR, MODE_NEAREST, MODE_LINEAR, MODE_NEAREST,
                                       MODE_LINEAR, MODE_LINEAR};
      logic [15:0] ph_scale  [1:10] = '{16'hFFFF, 16'd8192, 16'd4096, 16'd1, 16'd1024,
                                       16'd0, 16'd3000, 16'd20000, 16'd6000, 16'd4095};
      logic [8:0]  ph_width  [1:10] = '{9'd16, 9'd1, 9'd16, 9'd8, 9'd16, 9'd511, 9'd256,
                                       9'd12, 9'd0, 9'd9};
      logic [8:0]  ph_height [1:10] = '{9'd16, 9'd1, 9'd16, 9'd8, 9'd16, 9'd300, 9'd256,
                                       9'd5, 9'd16, 9'd14};
      int kind;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_WRITE;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = REG_SCALE_MODE;
      csr_wdata  = '0;
      mode_q     = MODE_NEAREST;
      scale_q    = 16'd4096;
      width_q    = 9'd256;
      height_q   = 9'd256;
      send_idle  = 0;
      recv_stall = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load a 12x12 corner, the far corners and extreme colours
      for (int y = 0; y < 12; y++)
         for (int x = 0; x < 12; x++)
            send_beat(OP_WRITE, 12'(x), 12'(y), 24'($urandom));
      send_beat(OP_WRITE, 12'd0, 12'd0, 24'h000000);
      send_beat(OP_WRITE, 12'd11, 12'd11, 24'hFFFFFF);
      send_beat(OP_WRITE, 12'd255, 12'd255, 24'hFFFFFF);
      send_beat(OP_WRITE, 12'd255, 12'd0, 24'h00FF00);
      send_beat(OP_WRITE, 12'd0, 12'd255, 24'hFF00FF);
      send_beat(OP_WRITE, 12'hFFF, 12'hFFF, 24'h123456);
      send_beat(OP_WRITE, 12'd256, 12'd0, 24'hABCDEF);
      send_sample(12'd0, 12'd0);
      send_sample(12'd11, 12'd11);
      send_sample(12'd255, 12'd255);
      send_sample(12'd255, 12'd0);
      send_sample(12'd0, 12'd255);
      send_sample(12'd256, 12'd0);
      send_sample(12'hFFF, 12'hFFF);

      for (int ph = 1; ph <= 10; ph++) begin
         drain_and_settle();
         write_reg(REG_SCALE_MODE, {15'd0, ph_mode[ph]});
         write_reg(REG_SCALE_FACTOR, ph_scale[ph]);
         write_reg(REG_SOURCE_WIDTH, {7'd0, ph_width[ph]});
         write_reg(REG_SOURCE_HEIGHT, {7'd0, ph_height[ph]});
         kind = ph % 4;
         send_idle  = (kind == 1) ? 75 : (kind == 3) ? 30 : 0;
         recv_stall = (kind == 2) ? 75 : (kind == 3) ? 30 : 0;
         // fresh content inside the loaded corner, some writes off the store
         for (int i = 0; i < 10; i++) begin
            if ($urandom_range(4) == 0)
               send_beat(OP_WRITE, 12'($urandom_range(256, 4095)), 12'($urandom),
                         24'($urandom));
            else
               send_beat(OP_WRITE, 12'($urandom_range(11)), 12'($urandom_range(11)),
                         24'($urandom));
         end
         for (int i = 0; i < 20; i++) send_sample(near_coord(), near_coord());
      end

      drain_and_settle();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[image_resampling_scaler_top] OK");
      else
         $display("[image_resampling_scaler_top] ERROR");
      $finish;
   end

endmodule
